@@ design/srms_pkg.sv @@
package srms_pkg;

  localparam int MaxStepsDef = 32;
  localparam int WordW       = 32;
  localparam int HistW       = 15;
  localparam int OutPosW     = 5;
  localparam int OutDataW    = 8;
  localparam int RunModeW    = 4;
  localparam int NumStepsW   = 6;
  localparam int CfgAddrW    = 1;
  localparam int CfgDataW    = 6;

  // register indexes
  localparam logic [CfgAddrW-1:0] RegRunMode  = 1'd0;
  localparam logic [CfgAddrW-1:0] RegNumSteps = 1'd1;

  // run modes
  localparam logic [RunModeW-1:0] ModeFwd      = 4'd0;
  localparam logic [RunModeW-1:0] ModeFwd2     = 4'd1;
  localparam logic [RunModeW-1:0] ModeFwd3     = 4'd2;
  localparam logic [RunModeW-1:0] ModeFwd4     = 4'd3;
  localparam logic [RunModeW-1:0] ModeRev      = 4'd4;
  localparam logic [RunModeW-1:0] ModePingPong = 4'd5;
  localparam logic [RunModeW-1:0] ModePendulum = 4'd6;
  localparam logic [RunModeW-1:0] ModeBrownian = 4'd7;
  localparam logic [RunModeW-1:0] ModeRandom   = 4'd8;
  localparam logic [RunModeW-1:0] ModeRandom2  = 4'd9;

  // history windows, one per mode family
  localparam logic [HistW-1:0] BaseFwd      = 15'h1000;
  localparam logic [HistW-1:0] BaseRev      = 15'h2000;
  localparam logic [HistW-1:0] BasePingPong = 15'h3000;
  localparam logic [HistW-1:0] BasePendulum = 15'h4000;
  localparam logic [HistW-1:0] BaseBrownian = 15'h5000;
  localparam logic [HistW-1:0] BaseRandom   = 15'h6000;
  localparam logic [HistW-1:0] WinSpan      = 15'h0FFF;

  localparam logic [HistW-1:0] SeedRev      = 15'h2001;
  localparam logic [HistW-1:0] SeedPingPong = 15'h3002;
  localparam logic [HistW-1:0] SeedPendulum = 15'h4002;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CALC,
    ST_PUSH
  } state_e;

endpackage

@@ design/sequencer_run_mode_stepper.sv @@
// Step-position advancer for a step sequencer. Each transaction on the slave stream is one
// clock event carrying a 32-bit random word; the block answers with exactly one transaction on
// the master stream holding the new step position and a boundary flag. An event is accepted,
// then reduced in the bit-serial remainder unit (32 shift-subtract steps, then its done flag;
// word modulo the step count, or modulo 3 in brownian mode), then the position and history
// are updated, then the output register is loaded; s_axis_tready is low meanwhile, so no new
// event is taken before the last is through. The result waits in the output register, so a
// stalled consumer only holds up the next event once its result is ready. The user must write
// run_mode and num_steps through the cfg port only while idle; the block does not enforce it.
module sequencer_run_mode_stepper import srms_pkg::*; #(
  parameter int MAX_STEPS = MaxStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [WordW-1:0]    s_axis_tdata,   // [31:0] random_word
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [4:0] step_position, [5] boundary_crossed
);

  localparam int PW = $clog2(MAX_STEPS);
  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam int CW = (NW > NumStepsW) ? NW : NumStepsW;
  localparam int EW = NW + 1;

  state_e state_q, state_d;

  logic [RunModeW-1:0]  run_mode_q;
  logic [NumStepsW-1:0] num_steps_q;
  logic [PW-1:0]        pos_q;
  logic [HistW-1:0]     hc_q;
  logic [OutPosW-1:0]   res_pos_q;
  logic                 res_cross_q;
  logic                 m_valid_q;
  logic [OutDataW-1:0]  m_data_q;

  logic [CW-1:0] steps_ext;
  logic [NW-1:0] n_w;
  logic [NW-1:0] divisor;
  logic [NW-1:0] rem;
  logic          div_done;
  logic          in_accept;
  logic          load_out;

  logic [EW-1:0]    pos_e, n_e, pos_inc, pos_dec, n_m1, n_m2, pos_nxt;
  logic [HistW-1:0] base, seed, hc_s, hc_m1, hc_m2, hc_nxt;
  logic [HistW-1:0] passes;
  logic             crossed;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  // clamp the step count to 1..MAX_STEPS
  assign steps_ext = CW'(num_steps_q);
  always_comb begin
    if (steps_ext == '0) begin
      n_w = NW'(1);
    end else if (steps_ext > CW'(MAX_STEPS)) begin
      n_w = NW'(MAX_STEPS);
    end else begin
      n_w = NW'(steps_ext);
    end
  end

  assign divisor = (run_mode_q == ModeBrownian) ? NW'(3) : n_w;

  srms_mod_unit #(
    .DivW(NW)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_accept),
    .dividend_i(s_axis_tdata),
    .divisor_i (divisor),
    .done_o    (div_done),
    .rem_o     (rem)
  );

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q  <= ModeFwd;
      num_steps_q <= NumStepsW'(16);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegRunMode:  run_mode_q  <= cfg_wdata_i[RunModeW-1:0];
        RegNumSteps: num_steps_q <= cfg_wdata_i[NumStepsW-1:0];
        default: ;
      endcase
    end
  end

  // history window of the current mode, re-seeded when foreign
  always_comb begin
    passes = HistW'(1);
    case (run_mode_q)
      ModeRev: begin
        base = BaseRev;
        seed = SeedRev;
      end
      ModePingPong: begin
        base = BasePingPong;
        seed = SeedPingPong;
      end
      ModePendulum: begin
        base = BasePendulum;
        seed = SeedPendulum;
      end
      ModeBrownian: begin
        base = BaseBrownian;
        seed = BaseBrownian + HistW'(n_w);
      end
      ModeRandom, ModeRandom2: begin
        base = BaseRandom;
        seed = BaseRandom + HistW'(n_w);
      end
      ModeFwd, ModeFwd2, ModeFwd3, ModeFwd4: begin
        passes = HistW'(run_mode_q) + HistW'(1);
        base   = BaseFwd;
        seed   = BaseFwd + passes;
      end
      default: begin
        base = BaseFwd;
        seed = BaseFwd + passes;
      end
    endcase
  end

  assign hc_s  = (hc_q < base + HistW'(1) || hc_q > base + WinSpan) ? seed : hc_q;
  assign hc_m1 = hc_s - HistW'(1);
  assign hc_m2 = hc_s - HistW'(2);

  assign pos_e   = EW'(pos_q);
  assign n_e     = EW'(n_w);
  assign pos_inc = pos_e + EW'(1);
  assign pos_dec = pos_e - EW'(1);
  assign n_m1    = n_e - EW'(1);
  assign n_m2    = n_e - EW'(2);

  // position and history update
  always_comb begin
    pos_nxt = pos_e;
    hc_nxt  = hc_s;
    crossed = 1'b0;
    case (run_mode_q)
      ModeRev: begin
        if (pos_e == '0) begin
          pos_nxt = n_m1;
          hc_nxt  = hc_m1;
          crossed = (hc_m1 <= base);
        end else begin
          pos_nxt = pos_dec;
        end
      end
      ModePingPong: begin
        if (!hc_s[0]) begin
          if (pos_inc >= n_e) begin
            pos_nxt = n_m1;
            hc_nxt  = hc_m1;
          end else begin
            pos_nxt = pos_inc;
          end
        end else if (pos_e == '0) begin
          pos_nxt = '0;
          hc_nxt  = hc_m1;
          crossed = (hc_m1 <= base);
        end else begin
          pos_nxt = pos_dec;
        end
      end
      ModePendulum: begin
        if (!hc_s[0]) begin
          if (pos_inc >= n_e) begin
            // one or two steps: turn-round lands on 0 and the back phase is skipped
            if (n_e <= EW'(2)) begin
              pos_nxt = '0;
              hc_nxt  = hc_m2;
              crossed = (hc_m2 <= base);
            end else begin
              pos_nxt = n_m2;
              hc_nxt  = hc_m1;
            end
          end else begin
            pos_nxt = pos_inc;
          end
        end else if (pos_e <= EW'(1)) begin
          pos_nxt = '0;
          hc_nxt  = hc_m1;
          crossed = (hc_m1 <= base);
        end else begin
          pos_nxt = pos_dec;
        end
      end
      ModeBrownian: begin
        case (rem[1:0])
          2'd0: begin
            if (pos_e == '0) begin
              pos_nxt = n_m1;
            end else begin
              pos_nxt = (pos_dec >= n_e) ? '0 : pos_dec;
            end
          end
          2'd2: pos_nxt = (pos_inc >= n_e) ? '0 : pos_inc;
          default: pos_nxt = (pos_e >= n_e) ? '0 : pos_e;
        endcase
        hc_nxt  = hc_m1;
        crossed = (hc_m1 <= base);
      end
      ModeRandom, ModeRandom2: begin
        pos_nxt = EW'(rem);
        hc_nxt  = hc_m1;
        crossed = (hc_m1 <= base);
      end
      default: begin
        if (pos_inc >= n_e) begin
          pos_nxt = '0;
          hc_nxt  = hc_m1;
          crossed = (hc_m1 <= base);
        end else begin
          pos_nxt = pos_inc;
        end
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hc_q  <= '0;
    end else if (state_q == ST_CALC) begin
      pos_q <= PW'(pos_nxt);
      hc_q  <= hc_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      res_pos_q   <= OutPosW'(pos_nxt);
      res_cross_q <= crossed;
    end
    if (load_out) begin
      m_data_q <= OutDataW'({res_cross_q, res_pos_q});
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

@@ design/srms_mod_unit.sv @@
module srms_mod_unit import srms_pkg::*; #(
  parameter int DivW = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] dividend_i,
  input  logic [DivW-1:0]  divisor_i,
  output logic             done_o,
  output logic [DivW-1:0]  rem_o
);

  localparam int CntW = $clog2(WordW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] sh_q, sh_d;
  logic [DivW-1:0]  div_q, div_d;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [DivW:0]    trial;
  logic [DivW:0]    diff;

  // one restoring step per cycle, msb of the dividend first
  assign trial = {rem_q, sh_q[WordW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(WordW - 1);
      sh_d   = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      sh_d  = {sh_q[WordW-2:0], 1'b0};
      rem_d = (trial >= {1'b0, div_q}) ? diff[DivW-1:0] : trial[DivW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ design/srms_checker.sv @@
module srms_checker import srms_pkg::*; #(
  parameter int MAX_STEPS = MaxStepsDef
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // not ready again at the start of the remainder pass after an event is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input accepted again during computation");

  // a fresh result appears exactly when the block goes idle again
  a_result_ends_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $rose(s_axis_tready))
    else $error("result appeared outside the end of an event");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(m_axis_tdata[OutPosW-1:0]) < MAX_STEPS)
                      && (m_axis_tdata[OutDataW-1:OutPosW+1] == '0))
    else $error("step position out of range");

endmodule

bind sequencer_run_mode_stepper srms_checker #(.MAX_STEPS(MAX_STEPS)) u_srms_checker (.*);
